// ----- rtl/core/cna_pkg.sv -----
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types and constants for the console number-to-ascii emitter.
// ----------------------------------------------------------------------------
package cna_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [7:0] byte_t;

  localparam opcode_t OP_CHAR = 2'd0;
  localparam opcode_t OP_HEX  = 2'd1;
  localparam opcode_t OP_DEC  = 2'd2;

  localparam byte_t ASCII_LF   = 8'h0A;
  localparam byte_t ASCII_CR   = 8'h0D;
  localparam byte_t ASCII_ZERO = 8'h30;
  localparam byte_t ASCII_X    = 8'h78;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR,
    ST_CHAR,
    ST_HEX0,
    ST_HEXX,
    ST_HEXDIG,
    ST_DECCONV,
    ST_DECSKIP,
    ST_DECDIG
  } state_t;

  // nibble to lower-case hex/decimal digit character
  function automatic byte_t digit_char(input logic [3:0] nib);
    byte_t c;
    case (nib)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      4'hf: c = 8'h66;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/cna_bcd_conv.sv -----
// ----------------------------------------------------------------------------
// cna_bcd_conv
// Shift-and-add-3 binary to bcd converter, one value bit per cycle.
// ----------------------------------------------------------------------------
module cna_bcd_conv #(
  parameter int VALUE_WIDTH = 64,
  parameter int NDEC        = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   done,
  output logic [NDEC*4-1:0]      bcd
);
  import cna_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CW-1:0]          cnt_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [NDEC*4-1:0]      bcd_r;
  logic [NDEC*4-1:0]      adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(VALUE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      bcd_r <= '0;
    end else if (busy_r) begin
      val_r <= val_r << 1;
      bcd_r <= {adj[NDEC*4-2:0], val_r[VALUE_WIDTH-1]};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ----- rtl/core/console_number_to_ascii_emitter.sv -----
// ----------------------------------------------------------------------------
// console_number_to_ascii_emitter
// Turns print requests into a run of ascii bytes for a serial transmitter.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until its last byte has
// been loaded into the output register. A character request gives one byte
// (two for a line feed, sent as carriage return then line feed). A hex request
// gives "0x" and (VALUE_WIDTH+3)/4 digits, one per cycle while out_stall is
// low. A decimal request first runs the shift-and-add-3 converter, then drops
// leading zeros (keeping at least one digit) and sends the digits that remain,
// one per cycle while out_stall is low. Opcode 3 is taken and gives no bytes.
// Only the low VALUE_WIDTH bits of in_value are used.
module console_number_to_ascii_emitter #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cna_pkg::opcode_t     in_opcode,
  input  cna_pkg::byte_t       in_character,
  input  logic [63:0]          in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cna_pkg::byte_t       out_byte,
  output logic                 out_last
);
  import cna_pkg::*;

  localparam int NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NHEX = (VALUE_WIDTH + 3) / 4;
  localparam int DW   = NDEC * 4;
  localparam int HW   = NHEX * 4;
  localparam int NCW  = $clog2(NDEC + 1);

  state_t           state_r, state_nxt;
  logic [DW-1:0]    digits_r, digits_nxt;
  logic [NCW-1:0]   cnt_r, cnt_nxt;
  byte_t            char_r, char_nxt;
  logic             out_valid_r;
  byte_t            out_byte_r;
  logic             out_last_r;

  logic             accept;
  logic             emit_ok;
  logic             emit;
  byte_t            emit_byte;
  logic             emit_last;
  logic             conv_start;
  logic             conv_done;
  logic [DW-1:0]    conv_bcd;
  logic [HW-1:0]    hex_val;
  logic [3:0]       top_nib;
  logic             last_digit;

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign emit_ok    = !out_valid_r || !out_stall;
  assign hex_val    = HW'(in_value[VALUE_WIDTH-1:0]);
  assign top_nib    = digits_r[DW-1 -: 4];
  assign last_digit = (cnt_r == NCW'(1));
  assign conv_start = accept && (in_opcode == OP_DEC);

  cna_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDEC        (NDEC)
  ) u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (in_value[VALUE_WIDTH-1:0]),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // byte produced by the current state
  always_comb begin
    emit      = 1'b0;
    emit_byte = ASCII_ZERO;
    emit_last = 1'b0;
    case (state_r)
      ST_CR: begin
        emit      = emit_ok;
        emit_byte = ASCII_CR;
      end
      ST_CHAR: begin
        emit      = emit_ok;
        emit_byte = char_r;
        emit_last = 1'b1;
      end
      ST_HEX0: begin
        emit      = emit_ok;
        emit_byte = ASCII_ZERO;
      end
      ST_HEXX: begin
        emit      = emit_ok;
        emit_byte = ASCII_X;
      end
      ST_HEXDIG, ST_DECDIG: begin
        emit      = emit_ok;
        emit_byte = digit_char(top_nib);
        emit_last = last_digit;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_CHAR: state_nxt = (in_character == ASCII_LF) ? ST_CR : ST_CHAR;
            OP_HEX:  state_nxt = ST_HEX0;
            OP_DEC:  state_nxt = ST_DECCONV;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CR:      if (emit) state_nxt = ST_CHAR;
      ST_CHAR:    if (emit) state_nxt = ST_IDLE;
      ST_HEX0:    if (emit) state_nxt = ST_HEXX;
      ST_HEXX:    if (emit) state_nxt = ST_HEXDIG;
      ST_HEXDIG, ST_DECDIG: begin
        if (emit && last_digit) state_nxt = ST_IDLE;
      end
      ST_DECCONV: if (conv_done) state_nxt = ST_DECSKIP;
      ST_DECSKIP: begin
        if (last_digit || top_nib != 4'd0) state_nxt = ST_DECDIG;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // digit register and counters
  always_comb begin
    digits_nxt = digits_r;
    cnt_nxt    = cnt_r;
    char_nxt   = char_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          char_nxt   = in_character;
          // hex digits left-aligned in the digit register
          digits_nxt = DW'(hex_val) << (DW - HW);
          cnt_nxt    = NCW'(NHEX);
        end
      end
      ST_HEXDIG, ST_DECDIG: begin
        if (emit) begin
          digits_nxt = digits_r << 4;
          cnt_nxt    = cnt_r - NCW'(1);
        end
      end
      ST_DECCONV: begin
        if (conv_done) begin
          digits_nxt = conv_bcd;
          cnt_nxt    = NCW'(NDEC);
        end
      end
      ST_DECSKIP: begin
        // drop leading zeros, keep at least one digit
        if (!last_digit && top_nib == 4'd0) begin
          digits_nxt = digits_r << 4;
          cnt_nxt    = cnt_r - NCW'(1);
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    cnt_r    <= cnt_nxt;
    char_r   <= char_nxt;
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
